// ===== rtl/dyad_gradient_accumulator_top_macros.svh =====
// Assertion macros for the dyad gradient accumulator
`ifndef DYAD_GRADIENT_ACCUMULATOR_TOP_MACROS_SVH
`define DYAD_GRADIENT_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication, checked on clock, off during reset
`define DGA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DGA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dga_pkg.sv =====
// Shared types, codes and constant tables of the dyad gradient accumulator
package dga_pkg;

   // input commands
   localparam logic [1:0] CMD_LOAD_PARAM = 2'd0;
   localparam logic [1:0] CMD_LOAD_MEMB  = 2'd1;
   localparam logic [1:0] CMD_LOAD_ADJ   = 2'd2;
   localparam logic [1:0] CMD_COMPUTE    = 2'd3;

   // register select (paddr bit 2)
   localparam logic REG_NODE_COUNT  = 1'b0;
   localparam logic REG_CLASS_COUNT = 1'b1;

   localparam int PARAM_DEPTH  = 8;
   localparam int RESULT_LIMIT = 8;
   localparam int ACC_W        = 48;
   localparam int TERM_W       = 38;
   localparam int PROB_W       = 17;

   // shared multiplier
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 19;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // shared divider
   localparam int DIV_N_W = 33;
   localparam int DIV_D_W = 19;
   localparam int DIV_Q_W = 17;

   localparam logic signed [MUL_B_W-1:0] LOG2E_Q16 = 19'sd94548;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef logic [16:0] pow_table_type [256];

   // 2^(i/256) in Q.16 from a fixed-point root-step recurrence
   function automatic pow_table_type build_pow_table();
      pow_table_type tab;
      logic [63:0]   t;
      t = 64'd1 << 30;
      for (int i = 0; i < 256; i++) begin
         tab[i] = 17'((t + 64'd8192) >> 14);
         t = (t * 64'd1076653033 + (64'd1 << 29)) >> 30;
      end
      return tab;
   endfunction

   localparam pow_table_type POW_TABLE = build_pow_table();

endpackage

// ===== rtl/dga_mul.sv =====
// Shared signed multiplier with registered product
module dga_mul (
   input  logic                                  clock,
   input  logic signed [dga_pkg::MUL_A_W-1:0]    op_a,
   input  logic signed [dga_pkg::MUL_B_W-1:0]    op_b,
   output logic signed [dga_pkg::MUL_P_W-1:0]    product
);

   logic signed [dga_pkg::MUL_P_W-1:0] product_ff;
   logic signed [dga_pkg::MUL_P_W-1:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/dga_div.sv =====
// Restoring divider, one quotient bit per cycle
module dga_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dga_pkg::DIV_N_W-1:0]   numer,
   input  logic [dga_pkg::DIV_D_W-1:0]   denom,
   output logic                          done,
   output logic [dga_pkg::DIV_Q_W-1:0]   quot
);

   localparam int N_W = dga_pkg::DIV_N_W;
   localparam int D_W = dga_pkg::DIV_D_W;
   localparam int C_W = $clog2(N_W + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic [D_W-1:0] rem_ff, rem_in;
   logic [N_W-1:0] q_ff, q_in;
   logic [D_W-1:0] den_ff, den_in;
   logic [D_W:0]   trial;
   logic           fits;

   always_comb begin
      trial   = {rem_ff, q_ff[N_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = C_W'(N_W);
         rem_in  = '0;
         q_in    = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? D_W'(trial - {1'b0, den_ff}) : D_W'(trial);
         q_in   = {q_ff[N_W-2:0], fits};
         cnt_in = cnt_ff - C_W'(1);
         if (cnt_ff == C_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff[dga_pkg::DIV_Q_W-1:0];

endmodule

// ===== rtl/dyad_gradient_accumulator_top.sv =====
// Dyad gradient accumulator: loads, softmax table build, pair walk, result drain
//
//   channel | direction | handshake         | beat
//   req     | in        | req_valid/ready   | one load or compute command
//   rsp     | out       | rsp_valid/ready   | one class result
//   csr     | in/out    | APB, pready high  | node_count (0x0), class_count (0x4)
//
// Loads are written on accept and can follow back to back. A compute beat builds
// the softmax table for all K*K class pairs, one divider run per probability,
// then walks the P = n*(n-1)/2 node pairs over all class pairs, K classes;
// one shared multiplier does all products. Then K result beats.
// req_ready is low from compute accept until the last result beat is taken.
// Reset is synchronous; stores hold no reset and must be written before use.
`include "dyad_gradient_accumulator_top_macros.svh"

module dyad_gradient_accumulator_top #(
   parameter int MAX_NODES   = 256,
   parameter int MAX_CLASSES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_node_a,
   input  logic [7:0]         req_node_b,
   input  logic [2:0]         req_class_index,
   input  logic signed [15:0] req_edge_param,
   input  logic signed [15:0] req_recip_param,
   input  logic [16:0]        req_weight,
   input  logic               req_edge_bit,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_class_out,
   output logic signed [47:0] rsp_edge_gradient,
   output logic signed [47:0] rsp_recip_gradient,
   output logic               rsp_last,
   output logic               rsp_saturated,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int CLASS_W    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int NCNT_W     = NODE_W + 1;
   localparam int KC_LIM     = (MAX_CLASSES < dga_pkg::RESULT_LIMIT) ? MAX_CLASSES
                                                                    : dga_pkg::RESULT_LIMIT;
   localparam int ADJ_DEPTH  = 1 << (2 * NODE_W);
   localparam int MEMB_DEPTH = 1 << (NODE_W + CLASS_W);
   localparam int ACC_W      = dga_pkg::ACC_W;
   localparam int TERM_W     = dga_pkg::TERM_W;
   localparam int PROB_W     = dga_pkg::PROB_W;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_CLR     = 5'd1;
   localparam logic [4:0] ST_PK      = 5'd2;
   localparam logic [4:0] ST_PL      = 5'd3;
   localparam logic [4:0] ST_MAX     = 5'd4;
   localparam logic [4:0] ST_EXMUL   = 5'd5;
   localparam logic [4:0] ST_EXTAB   = 5'd6;
   localparam logic [4:0] ST_SUM     = 5'd7;
   localparam logic [4:0] ST_DVGO    = 5'd8;
   localparam logic [4:0] ST_DVRUN   = 5'd9;
   localparam logic [4:0] ST_PRSTART = 5'd10;
   localparam logic [4:0] ST_ADJ1    = 5'd11;
   localparam logic [4:0] ST_ADJ2    = 5'd12;
   localparam logic [4:0] ST_ADJ3    = 5'd13;
   localparam logic [4:0] ST_GI      = 5'd14;
   localparam logic [4:0] ST_GJ      = 5'd15;
   localparam logic [4:0] ST_WMUL    = 5'd16;
   localparam logic [4:0] ST_WCAP    = 5'd17;
   localparam logic [4:0] ST_TMUL    = 5'd18;
   localparam logic [4:0] ST_TRND    = 5'd19;
   localparam logic [4:0] ST_TACC    = 5'd20;
   localparam logic [4:0] ST_OLOAD   = 5'd21;
   localparam logic [4:0] ST_OWAIT   = 5'd22;

   // control
   logic [4:0]        state_ff, state_in;
   logic [NCNT_W-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [3:0]        kc_ff, kc_in;
   logic [2:0]        k_ff, k_in, l_ff, l_in, oc_ff, oc_in;
   logic [1:0]        eidx_ff, eidx_in, pidx_ff, pidx_in, tsel_ff, tsel_in;
   logic [8:0]        node_count_ff;
   logic [3:0]        class_count_ff;

   // datapath
   logic [31:0]              pk_ff, pk_in, pl_ff, pl_in;
   logic signed [16:0]       a1_ff, a1_in, a2_ff, a2_in, a3_ff, a3_in, m_ff, m_in;
   logic [PROB_W-1:0]        e_ff [4];
   logic [PROB_W-1:0]        e_in [4];
   logic [18:0]              d_ff, d_in;
   logic [16:0]              gi_ff, gi_in;
   logic [33:0]              w_ff, w_in;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic                     fw_ff, fw_in, bw_ff, bw_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_class_ff, rsp_class_in;
   logic signed [ACC_W-1:0] rsp_edge_ff, rsp_edge_in, rsp_recip_ff, rsp_recip_in;
   logic                    rsp_last_ff, rsp_last_in, rsp_sat_ff, rsp_sat_in;

   // stores
   logic [31:0]              param_ff [dga_pkg::PARAM_DEPTH];
   logic signed [ACC_W-1:0]  edge_acc_ff [dga_pkg::RESULT_LIMIT];
   logic signed [ACC_W-1:0]  recip_acc_ff [dga_pkg::RESULT_LIMIT];
   logic                     sat_ff [dga_pkg::RESULT_LIMIT];
   logic                     adj_mem [ADJ_DEPTH];
   logic                     adj_q_ff;
   logic [PROB_W-1:0]        memb_mem [MEMB_DEPTH];
   logic [PROB_W-1:0]        memb_q_ff;
   logic [PROB_W-1:0]        p_fwd_mem [64];
   logic [PROB_W-1:0]        p_bwd_mem [64];
   logic [PROB_W-1:0]        p_mut_mem [64];
   logic [PROB_W-1:0]        p_fwd_q_ff, p_bwd_q_ff, p_mut_q_ff;

   // helpers
   logic                          accept, is_compute;
   logic                          adj_we, adj_re, memb_we, memb_re, param_we;
   logic [2*NODE_W-1:0]           adj_waddr, adj_raddr;
   logic [NODE_W+CLASS_W-1:0]     memb_waddr, memb_raddr;
   logic [16:0]                   weight_sat;
   logic [31:0]                   param_rd;
   logic [5:0]                    pair_addr;
   logic                          p_we;
   logic signed [dga_pkg::MUL_A_W-1:0] mul_a;
   logic signed [dga_pkg::MUL_B_W-1:0] mul_b;
   logic signed [dga_pkg::MUL_P_W-1:0] mul_p;
   logic                          div_start, div_done;
   logic [dga_pkg::DIV_N_W-1:0]   div_numer;
   logic [dga_pkg::DIV_Q_W-1:0]   div_quot;
   logic signed [17:0]            exp_a;
   logic [17:0]                   exp_u;
   logic [35:0]                   exp_r;
   logic [7:0]                    exp_n;
   logic [15:0]                   exp_f, exp_gneg;
   logic [8:0]                    exp_shift;
   logic [PROB_W-1:0]             exp_val, e_div;
   logic signed [16:0]            sm_a1, sm_a2, sm_a3, sm_m;
   logic [18:0]                   sm_sum;
   logic                          t_ind;
   logic [PROB_W-1:0]             t_p;
   logic signed [17:0]            t_diff;
   logic signed [dga_pkg::MUL_P_W-1:0] t_v;
   logic [2:0]                    rd_idx;
   logic signed [ACC_W-1:0]       acc_cur, acc_new;
   logic signed [ACC_W:0]         acc_sum;
   logic                          acc_ovf;
   logic                          l_more, k_more, j_more, i_more;
   logic [3:0]                    cc_fix;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign is_compute = accept && (req_command == dga_pkg::CMD_COMPUTE);

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign prdata = (paddr[2] == dga_pkg::REG_CLASS_COUNT) ? {28'd0, class_count_ff}
                                                          : {23'd0, node_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= 9'd2;
         class_count_ff <= 4'd1;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == dga_pkg::REG_CLASS_COUNT) begin
            class_count_ff <= pwdata[3:0];
         end else begin
            node_count_ff <= pwdata[8:0];
         end
      end
   end

   // ---------------- load path ----------------
   assign weight_sat = (req_weight > 17'd65536) ? 17'd65536 : req_weight;
   assign param_we   = accept && (req_command == dga_pkg::CMD_LOAD_PARAM)
                       && (32'(req_class_index) < MAX_CLASSES);
   assign memb_we    = accept && (req_command == dga_pkg::CMD_LOAD_MEMB)
                       && (32'(req_class_index) < MAX_CLASSES)
                       && (32'(req_node_a) < MAX_NODES);
   assign adj_we     = accept && (req_command == dga_pkg::CMD_LOAD_ADJ)
                       && (32'(req_node_a) < MAX_NODES) && (32'(req_node_b) < MAX_NODES);
   assign adj_waddr  = {NODE_W'(req_node_a), NODE_W'(req_node_b)};
   assign memb_waddr = {NODE_W'(req_node_a), CLASS_W'(req_class_index)};

   assign adj_re     = (state_ff == ST_ADJ1) || (state_ff == ST_ADJ2);
   assign adj_raddr  = (state_ff == ST_ADJ1) ? {i_ff[NODE_W-1:0], j_ff[NODE_W-1:0]}
                                             : {j_ff[NODE_W-1:0], i_ff[NODE_W-1:0]};
   assign memb_re    = (state_ff == ST_GI) || (state_ff == ST_GJ);
   assign memb_raddr = (state_ff == ST_GI) ? {i_ff[NODE_W-1:0], CLASS_W'(k_ff)}
                                           : {j_ff[NODE_W-1:0], CLASS_W'(l_ff)};
   assign pair_addr  = {k_ff, l_ff};
   assign param_rd   = param_ff[(state_ff == ST_PK) ? k_ff : l_ff];

   always_ff @(posedge clock) begin
      if (param_we) begin
         param_ff[req_class_index] <= {req_recip_param, req_edge_param};
      end
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_waddr] <= req_edge_bit;
      end
      if (adj_re) begin
         adj_q_ff <= adj_mem[adj_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (memb_we) begin
         memb_mem[memb_waddr] <= weight_sat;
      end
      if (memb_re) begin
         memb_q_ff <= memb_mem[memb_raddr];
      end
   end

   assign p_we = (state_ff == ST_DVRUN) && div_done;

   always_ff @(posedge clock) begin
      if (p_we && (pidx_ff == 2'd0)) begin
         p_fwd_mem[pair_addr] <= div_quot;
      end
      if (p_we && (pidx_ff == 2'd1)) begin
         p_bwd_mem[pair_addr] <= div_quot;
      end
      if (p_we && (pidx_ff == 2'd2)) begin
         p_mut_mem[pair_addr] <= div_quot;
      end
      if (state_ff == ST_GJ) begin
         p_fwd_q_ff <= p_fwd_mem[pair_addr];
         p_bwd_q_ff <= p_bwd_mem[pair_addr];
         p_mut_q_ff <= p_mut_mem[pair_addr];
      end
   end

   // ---------------- shared units ----------------
   dga_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign div_start = (state_ff == ST_DVGO);
   assign div_numer = {e_div, 16'd0} + {15'd0, d_ff[18:1]};

   dga_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (d_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ---------------- arithmetic helpers ----------------
   always_comb begin
      // exp(-u): u = m - logit
      unique case (eidx_ff)
         2'd0:    exp_a = 18'sd0;
         2'd1:    exp_a = {a1_ff[16], a1_ff};
         2'd2:    exp_a = {a2_ff[16], a2_ff};
         default: exp_a = {a3_ff[16], a3_ff};
      endcase
      exp_u     = 18'({m_ff[16], m_ff} - exp_a);
      exp_r     = 36'(mul_p[35:0]) + 36'd2048;
      exp_n     = exp_r[35:28];
      exp_f     = exp_r[27:12];
      exp_shift = {1'b0, exp_n} + ((exp_f != 16'd0) ? 9'd1 : 9'd0);
      exp_gneg  = 16'd0 - exp_f;
      exp_val   = (exp_shift >= 9'd17) ? '0
                : (dga_pkg::POW_TABLE[exp_gneg[15:8]] >> exp_shift[4:0]);

      // logits and their maximum
      sm_a1 = {pk_ff[15], pk_ff[15:0]};
      sm_a2 = {pl_ff[15], pl_ff[15:0]};
      sm_a3 = {pk_ff[31], pk_ff[31:16]} + {pl_ff[31], pl_ff[31:16]};
      sm_m  = 17'sd0;
      if (sm_a1 > sm_m) sm_m = sm_a1;
      if (sm_a2 > sm_m) sm_m = sm_a2;
      if (sm_a3 > sm_m) sm_m = sm_a3;
      sm_sum = 19'(e_ff[0]) + 19'(e_ff[1]) + 19'(e_ff[2]) + 19'(e_ff[3]);

      unique case (pidx_ff)
         2'd0:    e_div = e_ff[1];
         2'd1:    e_div = e_ff[2];
         default: e_div = e_ff[3];
      endcase

      // gradient term: w * (indicator - p), round to Q16.32
      unique case (tsel_ff)
         2'd0: begin
            t_ind = fw_ff && !bw_ff;
            t_p   = p_fwd_q_ff;
         end
         2'd1: begin
            t_ind = !fw_ff && bw_ff;
            t_p   = p_bwd_q_ff;
         end
         default: begin
            t_ind = fw_ff && bw_ff;
            t_p   = p_mut_q_ff;
         end
      endcase
      t_diff = $signed({1'b0, t_ind, 16'd0}) - $signed({1'b0, t_p});
      t_v    = mul_p + 54'sd32768;

      // one accumulator read per cycle
      rd_idx  = (state_ff == ST_OLOAD) ? oc_ff : (tsel_ff[0] ? l_ff : k_ff);
      acc_cur = tsel_ff[1] ? recip_acc_ff[rd_idx] : edge_acc_ff[rd_idx];
      acc_sum = {acc_cur[ACC_W-1], acc_cur} + (ACC_W+1)'(term_ff);
      acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
      acc_new = acc_ovf ? (acc_sum[ACC_W] ? dga_pkg::ACC_MIN : dga_pkg::ACC_MAX)
                        : acc_sum[ACC_W-1:0];

      // loop bounds
      l_more = ({1'b0, l_ff} + 4'd1) < kc_ff;
      k_more = ({1'b0, k_ff} + 4'd1) < kc_ff;
      j_more = ({1'b0, j_ff} + (NCNT_W+1)'(1)) < {1'b0, n_ff};
      i_more = ({1'b0, i_ff} + (NCNT_W+1)'(2)) < {1'b0, n_ff};
      cc_fix = (class_count_ff == 4'd0) ? 4'd1 : class_count_ff;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_EXMUL: begin
            mul_a = $signed({17'd0, exp_u});
            mul_b = dga_pkg::LOG2E_Q16;
         end
         ST_WMUL: begin
            mul_a = $signed({18'd0, gi_ff});
            mul_b = $signed({2'd0, memb_q_ff});
         end
         ST_TMUL: begin
            mul_a = $signed({1'b0, w_ff});
            mul_b = $signed({t_diff[17], t_diff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      kc_in        = kc_ff;
      k_in         = k_ff;
      l_in         = l_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      oc_in        = oc_ff;
      eidx_in      = eidx_ff;
      pidx_in      = pidx_ff;
      tsel_in      = tsel_ff;
      pk_in        = pk_ff;
      pl_in        = pl_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      a3_in        = a3_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      d_in         = d_ff;
      gi_in        = gi_ff;
      w_in         = w_ff;
      term_in      = term_ff;
      fw_in        = fw_ff;
      bw_in        = bw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_class_in = rsp_class_ff;
      rsp_edge_in  = rsp_edge_ff;
      rsp_recip_in = rsp_recip_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sat_in   = rsp_sat_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (is_compute) begin
               n_in     = (32'(node_count_ff) > MAX_NODES) ? NCNT_W'(MAX_NODES)
                                                           : NCNT_W'(node_count_ff);
               kc_in    = (32'(cc_fix) > KC_LIM) ? 4'(KC_LIM) : cc_fix;
               state_in = ST_CLR;
            end
         end
         ST_CLR: begin
            k_in     = '0;
            l_in     = '0;
            state_in = ST_PK;
         end
         ST_PK: begin
            pk_in    = param_rd;
            state_in = ST_PL;
         end
         ST_PL: begin
            pl_in    = param_rd;
            state_in = ST_MAX;
         end
         ST_MAX: begin
            a1_in    = sm_a1;
            a2_in    = sm_a2;
            a3_in    = sm_a3;
            m_in     = sm_m;
            eidx_in  = '0;
            state_in = ST_EXMUL;
         end
         ST_EXMUL: begin
            state_in = ST_EXTAB;
         end
         ST_EXTAB: begin
            e_in[eidx_ff] = exp_val;
            if (eidx_ff == 2'd3) begin
               state_in = ST_SUM;
            end else begin
               eidx_in  = eidx_ff + 2'd1;
               state_in = ST_EXMUL;
            end
         end
         ST_SUM: begin
            d_in     = (sm_sum == 19'd0) ? 19'd1 : sm_sum;
            pidx_in  = '0;
            state_in = ST_DVGO;
         end
         ST_DVGO: begin
            state_in = ST_DVRUN;
         end
         ST_DVRUN: begin
            if (div_done) begin
               if (pidx_ff != 2'd2) begin
                  pidx_in  = pidx_ff + 2'd1;
                  state_in = ST_DVGO;
               end else if (l_more) begin
                  l_in     = l_ff + 3'd1;
                  state_in = ST_PK;
               end else if (k_more) begin
                  k_in     = k_ff + 3'd1;
                  l_in     = '0;
                  state_in = ST_PK;
               end else begin
                  state_in = ST_PRSTART;
               end
            end
         end
         ST_PRSTART: begin
            i_in  = '0;
            j_in  = NCNT_W'(1);
            k_in  = '0;
            l_in  = '0;
            oc_in = '0;
            // fewer than two nodes: no pairs
            state_in = (n_ff < NCNT_W'(2)) ? ST_OLOAD : ST_ADJ1;
         end
         ST_ADJ1: begin
            state_in = ST_ADJ2;
         end
         ST_ADJ2: begin
            fw_in    = adj_q_ff;
            state_in = ST_ADJ3;
         end
         ST_ADJ3: begin
            bw_in    = adj_q_ff;
            state_in = ST_GI;
         end
         ST_GI: begin
            state_in = ST_GJ;
         end
         ST_GJ: begin
            gi_in    = memb_q_ff;
            state_in = ST_WMUL;
         end
         ST_WMUL: begin
            state_in = ST_WCAP;
         end
         ST_WCAP: begin
            w_in     = mul_p[33:0];
            tsel_in  = '0;
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            state_in = ST_TRND;
         end
         ST_TRND: begin
            term_in  = t_v[dga_pkg::MUL_P_W-1:16];
            state_in = ST_TACC;
         end
         ST_TACC: begin
            if (tsel_ff == 2'd2) begin
               // mutual term goes to both classes
               tsel_in = 2'd3;
            end else if (tsel_ff != 2'd3) begin
               tsel_in  = tsel_ff + 2'd1;
               state_in = ST_TMUL;
            end else if (l_more) begin
               l_in     = l_ff + 3'd1;
               state_in = ST_GI;
            end else if (k_more) begin
               k_in     = k_ff + 3'd1;
               l_in     = '0;
               state_in = ST_GI;
            end else if (j_more) begin
               j_in     = j_ff + NCNT_W'(1);
               k_in     = '0;
               l_in     = '0;
               state_in = ST_ADJ1;
            end else if (i_more) begin
               i_in     = i_ff + NCNT_W'(1);
               j_in     = i_ff + NCNT_W'(2);
               k_in     = '0;
               l_in     = '0;
               state_in = ST_ADJ1;
            end else begin
               oc_in    = '0;
               state_in = ST_OLOAD;
            end
         end
         ST_OLOAD: begin
            rsp_valid_in = 1'b1;
            rsp_class_in = oc_ff;
            rsp_edge_in  = edge_acc_ff[rd_idx];
            rsp_recip_in = recip_acc_ff[rd_idx];
            rsp_sat_in   = sat_ff[rd_idx];
            rsp_last_in  = ({1'b0, oc_ff} + 4'd1) == kc_ff;
            state_in     = ST_OWAIT;
         end
         ST_OWAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  oc_in    = oc_ff + 3'd1;
                  state_in = ST_OLOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         kc_ff        <= 4'd1;
         k_ff         <= '0;
         l_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         oc_ff        <= '0;
         eidx_ff      <= '0;
         pidx_ff      <= '0;
         tsel_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         kc_ff        <= kc_in;
         k_ff         <= k_in;
         l_ff         <= l_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         oc_ff        <= oc_in;
         eidx_ff      <= eidx_in;
         pidx_ff      <= pidx_in;
         tsel_ff      <= tsel_in;
      end
      pk_ff        <= pk_in;
      pl_ff        <= pl_in;
      a1_ff        <= a1_in;
      a2_ff        <= a2_in;
      a3_ff        <= a3_in;
      m_ff         <= m_in;
      e_ff         <= e_in;
      d_ff         <= d_in;
      gi_ff        <= gi_in;
      w_ff         <= w_in;
      term_ff      <= term_in;
      fw_ff        <= fw_in;
      bw_ff        <= bw_in;
      rsp_class_ff <= rsp_class_in;
      rsp_edge_ff  <= rsp_edge_in;
      rsp_recip_ff <= rsp_recip_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // accumulators, cleared at compute start
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLR) begin
         for (int c = 0; c < dga_pkg::RESULT_LIMIT; c++) begin
            edge_acc_ff[c]  <= '0;
            recip_acc_ff[c] <= '0;
            sat_ff[c]       <= 1'b0;
         end
      end else if (state_ff == ST_TACC) begin
         if (tsel_ff[1]) begin
            recip_acc_ff[rd_idx] <= acc_new;
         end else begin
            edge_acc_ff[rd_idx] <= acc_new;
         end
         if (acc_ovf) begin
            sat_ff[rd_idx] <= 1'b1;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_class_out      = rsp_class_ff;
   assign rsp_edge_gradient  = rsp_edge_ff;
   assign rsp_recip_gradient = rsp_recip_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_saturated      = rsp_sat_ff;

   // ---------------- assertions ----------------
   `DGA_ASSERT_IMP(a_no_accept_with_result, rsp_valid, !req_ready, "req open while result pending")
   `DGA_ASSERT_NXT(a_compute_goes_busy, is_compute, !req_ready, "compute beat did not go busy")
   `DGA_ASSERT_NXT(a_last_returns_idle, rsp_valid && rsp_ready && rsp_last, req_ready, "no idle after last")
   `DGA_ASSERT_IMP(a_div_done_in_wait, div_done, state_ff == ST_DVRUN, "divider done outside wait")

endmodule
